/* rtl/mrrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the byte-wide CRC-16 step for the Modbus
// read response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    localparam int unsigned MAX_READ_WORDS = 125;

    localparam int unsigned POS_W    = 9;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'hA001;
    localparam logic [7:0]       EXC_FLAG = 8'h80;
    localparam logic [LEN_W-1:0] MIN_LEN  = 10'd5;

    localparam logic [7:0]  FUNC_HOLDING = 8'd3;
    localparam logic [7:0]  FUNC_INPUT   = 8'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_ADDR     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_FUNCTION = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT    = 4'd2;

    localparam logic [7:0]  RST_UNIT_ADDR     = 8'd1;
    localparam logic [7:0]  RST_READ_FUNCTION = 8'd3;
    localparam logic [15:0] RST_WORD_COUNT    = 16'd1;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CONFIG    = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_ADDRESS   = 3'd4;
    localparam logic [2:0] ST_EXCEPTION = 3'd5;
    localparam logic [2:0] ST_FUNCTION  = 3'd6;

    typedef struct packed {
        logic [7:0]  unit_addr;
        logic [7:0]  read_function;
        logic [15:0] word_count;
    } cfg_t;

    // reflected CRC-16, one byte, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/modbus_read_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_read_response_checker
// Checks a Modbus RTU read holding/input registers response byte by byte:
// CRC-16, length, header, exception; emits data words and a final status.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction | word
//  ---------+--------------------------------+-----------+-----------------------
//  s_       | s_valid s_ready                | in        | rx_byte, frame_end
//  m_       | m_valid m_ready                | out       | kind, value, index,
//           |                                |           | status, exception code
//  cfg_     | cfg_valid cfg_ready            | in        | cfg_index, cfg_data
//
//  One byte per cycle. The CRC step, header compares and status priority
//  sit between the frame state registers and the result register.
//  A byte is taken whenever the result register is empty or being drained,
//  so a stalled m_ready holds off s_ready only while a result is waiting.
//  aresetn (synchronous) restores register defaults and clears the frame.
//  Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module modbus_read_response_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_frame_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_item_kind,
    output logic [15:0]                       m_word_value,
    output logic [mrrc_pkg::INDEX_W-1:0]      m_word_index,
    output logic [2:0]                        m_frame_status,
    output logic [7:0]                        m_exception_code
);
    import mrrc_pkg::*;

    cfg_t               cfg_reg;
    logic [15:0]        crc_reg, crc_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         func_reg, func_next;
    logic [7:0]         bcnt_reg, bcnt_next;
    logic [7:0]         hbl_reg, hbl_next;

    logic               m_valid_reg, m_valid_next;
    logic               kind_reg, kind_next;
    logic [15:0]        value_reg, value_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [2:0]         status_reg, status_next;
    logic [7:0]         exc_reg, exc_next;

    logic               accept;
    logic               cfg_ok;
    logic [7:0]         exc_fn;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   want;
    logic               bcnt_match;
    logic               header_ok;
    logic [POS_W-1:0]   pos_m4;
    logic [POS_W-1:0]   data_end;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign cfg_ok = ((cfg_reg.read_function == FUNC_HOLDING) ||
                     (cfg_reg.read_function == FUNC_INPUT)) &&
                    (cfg_reg.word_count >= 16'd1) &&
                    (cfg_reg.word_count <= 16'(MAX_READ_WORDS));
    assign exc_fn = cfg_reg.read_function | EXC_FLAG;

    always_comb begin
        crc_next   = crc16_byte(crc_reg, s_rx_byte);
        addr_next  = (pos_reg == 9'd0) ? s_rx_byte : addr_reg;
        func_next  = (pos_reg == 9'd1) ? s_rx_byte : func_reg;
        bcnt_next  = (pos_reg == 9'd2) ? s_rx_byte : bcnt_reg;
        pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 9'd1;
        hbl_next   = hbl_reg;

        len        = {1'b0, pos_reg} + 10'd1;
        bcnt_match = ({9'd0, bcnt_next} == {cfg_reg.word_count, 1'b0});
        header_ok  = cfg_ok && (addr_next == cfg_reg.unit_addr) &&
                     (func_next == cfg_reg.read_function) && bcnt_match;
        pos_m4     = pos_reg - 9'd4;
        data_end   = {1'b0, bcnt_next} + 9'd2;

        if (func_next == exc_fn) begin
            want = MIN_LEN;
        end else if (func_next == cfg_reg.read_function) begin
            want = MIN_LEN + {2'b00, bcnt_next};
        end else begin
            want = '0;
        end

        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        value_next   = value_reg;
        index_next   = index_reg;
        status_next  = status_reg;
        exc_next     = exc_reg;

        if (accept && s_frame_end) begin
            m_valid_next = 1'b1;
            kind_next    = KIND_STATUS;
            value_next   = '0;
            index_next   = '0;
            exc_next     = '0;
            if (!cfg_ok) begin
                status_next = ST_CONFIG;
            end else if (len < MIN_LEN) begin
                status_next = ST_LENGTH;
            end else if ((want != '0) && (len != want)) begin
                status_next = ST_LENGTH;
            end else if (crc_next != 16'h0000) begin
                status_next = ST_CRC;
            end else if (addr_next != cfg_reg.unit_addr) begin
                status_next = ST_ADDRESS;
            end else if (func_next == exc_fn) begin
                status_next = ST_EXCEPTION;
                exc_next    = bcnt_next;
            end else if (func_next != cfg_reg.read_function) begin
                status_next = ST_FUNCTION;
            end else if (!bcnt_match) begin
                status_next = ST_LENGTH;
            end else begin
                status_next = ST_OK;
            end
        end else if (accept && (pos_reg >= 9'd3) && header_ok &&
                     (pos_reg <= data_end)) begin
            // odd position: high byte of a word, even: low byte completes it
            if (pos_reg[0]) begin
                hbl_next = s_rx_byte;
            end else begin
                m_valid_next = 1'b1;
                kind_next    = KIND_WORD;
                value_next   = {hbl_reg, s_rx_byte};
                index_next   = pos_m4[INDEX_W:1];
                status_next  = ST_OK;
                exc_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_addr     <= RST_UNIT_ADDR;
            cfg_reg.read_function <= RST_READ_FUNCTION;
            cfg_reg.word_count    <= RST_WORD_COUNT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_UNIT_ADDR:     cfg_reg.unit_addr     <= cfg_data[7:0];
                REG_READ_FUNCTION: cfg_reg.read_function <= cfg_data[7:0];
                REG_WORD_COUNT:    cfg_reg.word_count    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            pos_reg     <= '0;
            addr_reg    <= '0;
            func_reg    <= '0;
            bcnt_reg    <= '0;
            hbl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                if (s_frame_end) begin
                    crc_reg  <= CRC_INIT;
                    pos_reg  <= '0;
                    addr_reg <= '0;
                    func_reg <= '0;
                    bcnt_reg <= '0;
                    hbl_reg  <= '0;
                end else begin
                    crc_reg  <= crc_next;
                    pos_reg  <= pos_next;
                    addr_reg <= addr_next;
                    func_reg <= func_next;
                    bcnt_reg <= bcnt_next;
                    hbl_reg  <= hbl_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        index_reg  <= index_next;
        status_reg <= status_next;
        exc_reg    <= exc_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_item_kind      = kind_reg;
    assign m_word_value     = value_reg;
    assign m_word_index     = index_reg;
    assign m_frame_status   = status_reg;
    assign m_exception_code = exc_reg;

    // end of frame always restarts the CRC and the byte counter
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_frame_end) |=> (pos_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after last byte");

    // word results carry OK status, no exception code, and an index below MAX_READ_WORDS
    a_word_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == KIND_WORD) |->
        (m_frame_status == ST_OK && m_exception_code == 8'd0 &&
         m_word_index < INDEX_W'(MAX_READ_WORDS)))
        else $error("malformed word result");

    // exception code only with an exception status
    a_exc_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_status != ST_EXCEPTION) |-> (m_exception_code == 8'd0))
        else $error("exception code without exception status");

    // a new result is only loaded when the previous one was taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !s_ready) |=> $stable(m_word_value))
        else $error("pending result overwritten");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus read response checker: directed frames
// with hand-read results, then randomized response frames under changing
// register settings and flow control, scored against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;
    import mrrc_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [15:0]        value;
        logic [INDEX_W-1:0] index;
        logic [2:0]         status;
        logic [7:0]         code;
    } result_t;

    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RES} chk_t;
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} src_t;

    typedef struct {
        src_t       src;
        logic [7:0] data;
        logic       last;
        chk_t       chk;
        result_t    res;
    } row_t;

    localparam result_t NO_RES = '0;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
    localparam int HOLD_CYCLES = 400;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [15:0]          cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte   = '0;
    logic                 s_frame_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_item_kind;
    logic [15:0]          m_word_value;
    logic [INDEX_W-1:0]   m_word_index;
    logic [2:0]           m_frame_status;
    logic [7:0]           m_exception_code;

    modbus_read_response_checker u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_frame_end      (s_frame_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item_kind      (m_item_kind),
        .m_word_value     (m_word_value),
        .m_word_index     (m_word_index),
        .m_frame_status   (m_frame_status),
        .m_exception_code (m_exception_code)
    );

    always #10 aclk = ~aclk;

    // predictor copy of registers and frame state
    logic [7:0]  pm_slave;
    logic [7:0]  pm_rfunc;
    logic [15:0] pm_words;
    logic [15:0] pm_crc;
    logic [8:0]  pm_pos;
    logic [7:0]  pm_addr;
    logic [7:0]  pm_func;
    logic [7:0]  pm_count;
    logic [7:0]  pm_high;

    // stimulus-side view of the registers, used to build frames
    logic [7:0]  cur_slave = RST_UNIT_ADDR;
    logic [7:0]  cur_rfunc = RST_READ_FUNCTION;
    logic [15:0] cur_words = RST_WORD_COUNT;
    bit          big_frames = 1'b0;

    result_t pending_results[$];
    row_t    rows[$];
    int      fail_cnt = 0;
    int      bytes_taken = 0;
    chk_t    row_chk = CHK_PRED;
    result_t row_res = '0;

    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic setup_ok();
        return (pm_rfunc == FUNC_HOLDING || pm_rfunc == FUNC_INPUT) &&
               pm_words >= 16'd1 && pm_words <= 16'(MAX_READ_WORDS);
    endfunction

    task clear_frame();
        pm_crc   = CRC_INIT;
        pm_pos   = '0;
        pm_addr  = '0;
        pm_func  = '0;
        pm_count = '0;
        pm_high  = '0;
    endtask

    task checker_step(input logic [7:0] b, input logic last,
                      output logic got, output result_t r);
        logic [8:0] pos;
        logic [7:0] exc_fn;
        int         len;
        int         want_len;
        logic       hdr_ok;
        pos = pm_pos;
        got = 1'b0;
        r = '0;
        pm_crc = crc16_step(pm_crc, b);
        if (pos == 9'd0) begin
            pm_addr = b;
        end else if (pos == 9'd1) begin
            pm_func = b;
        end else if (pos == 9'd2) begin
            pm_count = b;
        end
        if (pm_pos < POS_MAX) begin
            pm_pos = pm_pos + 9'd1;
        end
        exc_fn = pm_rfunc | EXC_FLAG;

        if (last) begin
            len = int'(pos) + 1;
            want_len = 0;
            if (pm_func == exc_fn) begin
                want_len = 5;
            end else if (pm_func == pm_rfunc) begin
                want_len = 5 + int'(pm_count);
            end
            r.kind = KIND_STATUS;
            if (!setup_ok()) begin
                r.status = ST_CONFIG;
            end else if (len < int'(MIN_LEN)) begin
                r.status = ST_LENGTH;
            end else if (want_len != 0 && len != want_len) begin
                r.status = ST_LENGTH;
            end else if (pm_crc != 16'd0) begin
                r.status = ST_CRC;
            end else if (pm_addr != pm_slave) begin
                r.status = ST_ADDRESS;
            end else if (pm_func == exc_fn) begin
                r.status = ST_EXCEPTION;
                r.code = pm_count;
            end else if (pm_func != pm_rfunc) begin
                r.status = ST_FUNCTION;
            end else if (int'(pm_count) != 2 * int'(pm_words)) begin
                r.status = ST_LENGTH;
            end else begin
                r.status = ST_OK;
            end
            got = 1'b1;
            clear_frame();
        end else if (pos >= 9'd3) begin
            hdr_ok = setup_ok() && pm_addr == pm_slave && pm_func == pm_rfunc &&
                     int'(pm_count) == 2 * int'(pm_words);
            if (hdr_ok && int'(pos) <= 2 + int'(pm_count)) begin
                if (pos[0]) begin
                    // first byte of a data word
                    pm_high = b;
                end else begin
                    r.kind = KIND_WORD;
                    r.value = {pm_high, b};
                    r.index = INDEX_W'((pos - 9'd4) >> 1);
                    got = 1'b1;
                end
            end
        end
    endtask

    // sample all handshakes at the rising edge
    always @(posedge aclk) begin : mon
        result_t seen;
        result_t want_r;
        result_t pr;
        logic    got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.kind   = m_item_kind;
                seen.value  = m_word_value;
                seen.index  = m_word_index;
                seen.status = m_frame_status;
                seen.code   = m_exception_code;
                if (pending_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected word: kind %0d value %h index %0d status %0d code %h",
                                 seen.kind, seen.value, seen.index, seen.status, seen.code);
                    end
                end else begin
                    want_r = pending_results.pop_front();
                    if (seen.kind !== want_r.kind || seen.value !== want_r.value ||
                        seen.index !== want_r.index || seen.status !== want_r.status ||
                        seen.code !== want_r.code) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch: want kind %0d value %h index %0d status %0d code %h",
                                     want_r.kind, want_r.value, want_r.index,
                                     want_r.status, want_r.code);
                            $display("          got  kind %0d value %h index %0d status %0d code %h",
                                     seen.kind, seen.value, seen.index, seen.status, seen.code);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_UNIT_ADDR:     pm_slave = cfg_data[7:0];
                    REG_READ_FUNCTION: pm_rfunc = cfg_data[7:0];
                    REG_WORD_COUNT:    pm_words = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                checker_step(s_rx_byte, s_frame_end, got, pr);
                if (row_chk == CHK_RES) begin
                    pending_results.insert(pending_results.size(), row_res);
                end else if (row_chk == CHK_PRED && got) begin
                    pending_results.insert(pending_results.size(), pr);
                end
                bytes_taken++;
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_byte(input logic [7:0] b, input logic last, input chk_t chk, input result_t res);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_rx_byte   <= b;
        s_frame_end <= last;
        row_chk     <= chk;
        row_res     <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        case (idx)
            REG_UNIT_ADDR:     cur_slave = d[7:0];
            REG_READ_FUNCTION: cur_rfunc = d[7:0];
            REG_WORD_COUNT:    cur_words = d;
            default: ;
        endcase
    endtask

    task set_setup(input logic [7:0] slave, input logic [7:0] rfunc, input logic [15:0] words);
        // upper data bits of the byte-wide registers are random on purpose
        write_reg(REG_UNIT_ADDR, {8'($urandom), slave});
        write_reg(REG_READ_FUNCTION, {8'($urandom), rfunc});
        write_reg(REG_WORD_COUNT, words);
        cfg_valid <= 1'b0;
    endtask

    task set_idling(input int gap, input int stall);
        send_gap_pct   <= gap;
        recv_stall_pct <= stall;
    endtask

    // registers change only with no frame byte or result in flight
    task wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_frame(input bit good_only);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          kind;
        int          nw;
        int          bc;
        int          n_send;
        kind = good_only ? 0 : $urandom_range(99);
        nw = (cur_words <= 16'd8 || big_frames) ? int'(cur_words) : $urandom_range(4, 1);
        if (kind < 90) begin
            fr.insert(fr.size(), cur_slave);
            if (kind >= 60 && kind < 68) begin
                fr.insert(fr.size(), cur_rfunc | EXC_FLAG);
                fr.insert(fr.size(), 8'($urandom));
            end else begin
                fr.insert(fr.size(), cur_rfunc);
                bc = (kind >= 74 && kind < 80) ? $urandom_range(13) : ((2 * nw) & 255);
                fr.insert(fr.size(), 8'(bc));
                repeat (bc) fr.insert(fr.size(), 8'($urandom));
            end
            if (kind >= 86) begin
                if ($urandom_range(1) == 0) begin
                    fr[0] = fr[0] ^ 8'($urandom_range(255, 1));
                end else begin
                    fr[1] = fr[1] ^ 8'($urandom_range(255, 1));
                end
            end
            crc = CRC_INIT;
            foreach (fr[k]) crc = crc16_step(crc, fr[k]);
            fr.insert(fr.size(), crc[7:0]);
            fr.insert(fr.size(), crc[15:8]);
            if (kind >= 68 && kind < 74) begin
                bc = $urandom_range(fr.size() - 1);
                fr[bc] = fr[bc] ^ (8'h01 << $urandom_range(7));
            end
        end else begin
            repeat ($urandom_range(20, 1)) fr.insert(fr.size(), 8'($urandom));
        end
        n_send = fr.size();
        if (kind >= 80 && kind < 86) begin
            n_send = $urandom_range(fr.size() - 1, 1);
        end
        for (int k = 0; k < n_send; k++) begin
            send_byte(fr[k], k == n_send - 1, CHK_PRED, NO_RES);
        end
    endtask

    task run_frames(input int n);
        int start;
        start = bytes_taken;
        while (bytes_taken - start < n) random_frame(1'b0);
    endtask

    function automatic row_t mk_row(src_t src, logic [7:0] d, logic last, chk_t chk,
                                    result_t res);
        row_t r;
        r.src  = src;
        r.data = d;
        r.last = last;
        r.chk  = chk;
        r.res  = res;
        return r;
    endfunction

    task add_row(input src_t src, input logic [7:0] d, input logic last, input chk_t chk,
                 input result_t res);
        rows.insert(rows.size(), mk_row(src, d, last, chk, res));
    endtask

    function automatic result_t status_res(logic [2:0] st, logic [7:0] code);
        result_t r;
        r = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        r.code   = code;
        return r;
    endfunction

    initial begin : stim
        result_t     w;
        logic [15:0] drv_crc;
        logic [15:0] tx_crc;
        logic [7:0]  b;

        pm_slave = RST_UNIT_ADDR;
        pm_rfunc = RST_READ_FUNCTION;
        pm_words = RST_WORD_COUNT;
        clear_frame();

        w = '0;
        w.kind  = KIND_WORD;
        w.value = 16'hFF00;
        // good reply with extreme data bytes
        add_row(SRC_LIT, 8'h01, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h03, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h02, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'hFF, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h00, 1'b0, CHK_RES, w);
        add_row(SRC_CRC_LO, 8'h00, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_CRC_HI, 8'h00, 1'b1, CHK_RES, status_res(ST_OK, 8'h00));
        // runt frame
        add_row(SRC_LIT, 8'hFF, 1'b1, CHK_RES, status_res(ST_LENGTH, 8'h00));
        // slave exception
        add_row(SRC_LIT, 8'h01, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h83, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h02, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_CRC_LO, 8'h00, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_CRC_HI, 8'h00, 1'b1, CHK_RES, status_res(ST_EXCEPTION, 8'h02));
        // wrong slave address
        add_row(SRC_LIT, 8'h00, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_LIT, 8'h03, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_LIT, 8'h02, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_LIT, 8'hFF, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_LIT, 8'hFF, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_CRC_LO, 8'h00, 1'b0, CHK_PRED, NO_RES);
        add_row(SRC_CRC_HI, 8'h00, 1'b1, CHK_RES, status_res(ST_ADDRESS, 8'h00));
        // function code differs from the expected one
        add_row(SRC_LIT, 8'h01, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h04, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_LIT, 8'h00, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_CRC_LO, 8'h00, 1'b0, CHK_NONE, NO_RES);
        add_row(SRC_CRC_HI, 8'h00, 1'b1, CHK_RES, status_res(ST_FUNCTION, 8'h00));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        drv_crc = CRC_INIT;
        tx_crc  = CRC_INIT;
        foreach (rows[i]) begin
            if (rows[i].src == SRC_CRC_LO) begin
                tx_crc = drv_crc;
                b = tx_crc[7:0];
            end else if (rows[i].src == SRC_CRC_HI) begin
                b = tx_crc[15:8];
            end else begin
                b = rows[i].data;
            end
            drv_crc = crc16_step(drv_crc, b);
            send_byte(b, rows[i].last, rows[i].chk, rows[i].res);
            if (rows[i].last) begin
                drv_crc = CRC_INIT;
            end
        end
        wait_idle();

        set_idling(0, 0);
        set_setup(8'h00, FUNC_INPUT, 16'd2);
        run_frames(15);
        wait_idle();

        // full-size data set, then short frames against the same count
        set_idling(46, 0);
        set_setup(8'hFF, FUNC_HOLDING, 16'(MAX_READ_WORDS));
        big_frames = 1'b1;
        random_frame(1'b1);
        big_frames = 1'b0;
        run_frames(5);
        wait_idle();

        set_idling(0, 46);
        set_setup(8'($urandom), FUNC_HOLDING, 16'd3);
        hold_req <= ~hold_req;
        run_frames(25);
        wait_idle();

        set_idling(18, 18);
        set_setup(8'($urandom), 8'h00, 16'd4);
        run_frames(10);
        wait_idle();

        set_idling(46, 0);
        set_setup(8'($urandom), FUNC_INPUT, 16'd0);
        run_frames(10);
        wait_idle();

        set_idling(0, 46);
        write_reg(REG_UNUSED_LO, 16'($urandom));
        write_reg(REG_UNUSED_HI, 16'($urandom));
        set_setup(8'($urandom), 8'hFF, 16'hFFFF);
        run_frames(10);
        wait_idle();

        // overlong frame: position saturates, ends in a length status
        set_idling(18, 18);
        set_setup(8'($urandom), FUNC_INPUT, 16'($urandom_range(8, 1)));
        hold_req <= ~hold_req;
        for (int k = 0; k < 514; k++) begin
            if (k == 0) begin
                b = cur_slave;
            end else if (k == 1) begin
                b = cur_rfunc;
            end else if (k == 2) begin
                b = 8'(2 * cur_words);
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, k == 513, CHK_PRED, NO_RES);
        end
        run_frames(10);
        wait_idle();

        set_idling(0, 0);
        set_setup(RST_UNIT_ADDR, RST_READ_FUNCTION, RST_WORD_COUNT);
        run_frames(15);
        wait_idle();
        repeat (16) @(negedge aclk);

        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
